FILE: rtl/fpeb_pkg.sv
// shared types, codes and the radius to alpha table of the four-pass blur
`default_nettype none

package fpeb_pkg;

  // largest tile side held in the store
  localparam int MAX_SIDE_DEFAULT = 128;

  // request opcodes (tuser of the input side, echoed as kind)
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_BLUR  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLUR_RADIUS = 2'd2;

  // register reset values
  localparam logic [7:0] TILE_WIDTH_RESET  = 8'd128;
  localparam logic [7:0] TILE_HEIGHT_RESET = 8'd128;
  localparam logic [5:0] BLUR_RADIUS_RESET = 6'd3;

  // filter coefficients in sixteenths
  localparam logic [4:0] ALPHA_FULL = 5'd16;
  localparam logic [4:0] ALPHA_MIN  = 5'd1;
  localparam logic [5:0] RADIUS_TABLE_TOP = 6'd17;
  localparam logic [4:0] ALPHA_TABLE [17] = '{
    5'd14, 5'd10, 5'd8, 5'd6, 5'd5, 5'd5, 5'd4, 5'd3, 5'd3,
    5'd3, 5'd3, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2
  };

  // blur sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CALC,
    ST_WR,
    ST_DONE
  } blur_state_t;

  // radius to alpha lookup
  function automatic logic [4:0] alpha_of(input logic [5:0] radius);
    logic [4:0] idx;
    idx = 5'(radius - 6'd1);
    if (radius == 6'd0) begin
      return ALPHA_FULL;
    end else if (radius > RADIUS_TABLE_TOP) begin
      return ALPHA_MIN;
    end else begin
      return ALPHA_TABLE[idx];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/four_pass_exponential_blur.sv
// four-pass recursive exponential blur over a tile store of four-channel pixels
// write and read requests: result in the next cycle; one per cycle while idle and not stalled
// blur request: four sweeps over the tile (none when w or h is zero), then the result;
// each non-seed pixel is a store read, four turns of the channel unit and a store write
// reset (synchronous, rst high) clears control, output and accumulators and loads
// register defaults; the tile store is not cleared and reads undefined until written
`default_nettype none

module four_pass_exponential_blur #(
  parameter int MAX_SIDE = fpeb_pkg::MAX_SIDE_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // col[6:0], row[13:7], in_ch0..in_ch3 [45:14], zero pad
  input  wire logic [1:0]  s_tuser,   // opcode
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // out_ch0, out_ch1, out_ch2, out_ch3
  output logic [1:0]       m_tuser,   // kind
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int LW = $clog2(MAX_SIDE + 1);
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  // configuration registers
  logic [7:0] tile_width;
  logic [7:0] tile_height;
  logic [5:0] blur_radius;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width  <= fpeb_pkg::TILE_WIDTH_RESET;
      tile_height <= fpeb_pkg::TILE_HEIGHT_RESET;
      blur_radius <= fpeb_pkg::BLUR_RADIUS_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        fpeb_pkg::REG_TILE_WIDTH:  tile_width  <= pwdata[7:0];
        fpeb_pkg::REG_TILE_HEIGHT: tile_height <= pwdata[7:0];
        fpeb_pkg::REG_BLUR_RADIUS: blur_radius <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      fpeb_pkg::REG_TILE_WIDTH:  prdata = {24'd0, tile_width};
      fpeb_pkg::REG_TILE_HEIGHT: prdata = {24'd0, tile_height};
      fpeb_pkg::REG_BLUR_RADIUS: prdata = {26'd0, blur_radius};
      default:                   prdata = 32'd0;
    endcase
  end

  // request fields
  logic [6:0]  in_col;
  logic [6:0]  in_row;
  logic [31:0] in_pixel;
  logic [1:0]  opcode;
  logic        in_accept;
  logic        in_inside;
  logic [AW-1:0] port_addr;

  assign in_col    = s_tdata[6:0];
  assign in_row    = s_tdata[13:7];
  assign in_pixel  = s_tdata[45:14];
  assign opcode    = s_tuser;
  assign in_accept = s_tvalid && s_tready;
  assign in_inside = (in_col < MAX_SIDE) && (in_row < MAX_SIDE);
  assign port_addr = AW'(AW'(CW'(in_row)) * AW'(MAX_SIDE) + AW'(CW'(in_col)));

  // effective tile size, clamped to the store
  logic [LW-1:0] w_eff;
  logic [LW-1:0] h_eff;
  logic [4:0]    alpha;

  assign w_eff = (tile_width  > MAX_SIDE) ? LW'(MAX_SIDE) : LW'(tile_width);
  assign h_eff = (tile_height > MAX_SIDE) ? LW'(MAX_SIDE) : LW'(tile_height);
  assign alpha = fpeb_pkg::alpha_of(blur_radius);

  // sequencer state and sweep counters
  fpeb_pkg::blur_state_t state, state_next;
  logic [1:0]    pass_idx;
  logic [CW-1:0] line_idx;
  logic [CW-1:0] pos_idx;
  logic [1:0]    ch_idx;

  // line geometry of the current pass
  logic [LW-1:0] lines;
  logic [LW-1:0] count;
  logic          pos_last;
  logic          line_last;
  logic          sweep_last;
  logic          pos_seed;
  logic [CW-1:0] blur_col;
  logic [CW-1:0] blur_row;
  logic [AW-1:0] blur_addr;

  assign lines      = pass_idx[0] ? h_eff : w_eff;
  assign count      = pass_idx[0] ? w_eff : h_eff;
  assign pos_last   = (LW'(pos_idx) == count - LW'(1));
  assign line_last  = (LW'(line_idx) == lines - LW'(1));
  assign sweep_last = pos_last && line_last && (pass_idx == 2'd3);
  assign pos_seed   = (pos_idx == '0);

  // pixel coordinates for down, right, up, left sweeps
  always_comb begin
    case (pass_idx)
      2'd0: begin
        blur_col = line_idx;
        blur_row = pos_idx;
      end
      2'd1: begin
        blur_col = pos_idx;
        blur_row = line_idx;
      end
      2'd2: begin
        blur_col = line_idx;
        blur_row = CW'(h_eff - LW'(1) - LW'(pos_idx));
      end
      default: begin
        blur_col = CW'(w_eff - LW'(1) - LW'(pos_idx));
        blur_row = line_idx;
      end
    endcase
  end

  assign blur_addr = AW'(AW'(blur_row) * AW'(MAX_SIDE) + AW'(blur_col));

  // sequencer controls
  logic blur_start;
  logic seq_read;
  logic seq_seed;
  logic seq_step;
  logic seq_write;
  logic seq_advance;
  logic blur_done;

  assign blur_start = in_accept && (opcode == fpeb_pkg::OP_BLUR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fpeb_pkg::ST_IDLE: begin
        if (blur_start) begin
          if (w_eff == '0 || h_eff == '0) begin
            state_next = fpeb_pkg::ST_DONE;
          end else begin
            state_next = fpeb_pkg::ST_RD;
          end
        end
      end
      fpeb_pkg::ST_RD: state_next = fpeb_pkg::ST_CALC;
      fpeb_pkg::ST_CALC: begin
        if (pos_seed) begin
          state_next = sweep_last ? fpeb_pkg::ST_DONE : fpeb_pkg::ST_RD;
        end else if (ch_idx == 2'd3) begin
          state_next = fpeb_pkg::ST_WR;
        end
      end
      fpeb_pkg::ST_WR: state_next = sweep_last ? fpeb_pkg::ST_DONE : fpeb_pkg::ST_RD;
      fpeb_pkg::ST_DONE: state_next = fpeb_pkg::ST_IDLE;
      default: state_next = fpeb_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    seq_read  = 1'b0;
    seq_seed  = 1'b0;
    seq_step  = 1'b0;
    seq_write = 1'b0;
    blur_done = 1'b0;
    case (state)
      fpeb_pkg::ST_RD:   seq_read = 1'b1;
      fpeb_pkg::ST_CALC: begin
        seq_seed = pos_seed;
        seq_step = !pos_seed;
      end
      fpeb_pkg::ST_WR:   seq_write = 1'b1;
      fpeb_pkg::ST_DONE: blur_done = 1'b1;
      default: ;
    endcase
  end

  assign seq_advance = seq_seed || seq_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpeb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_idx <= 2'd0;
      line_idx <= '0;
      pos_idx  <= '0;
      ch_idx   <= 2'd0;
    end else if (blur_start) begin
      pass_idx <= 2'd0;
      line_idx <= '0;
      pos_idx  <= '0;
      ch_idx   <= 2'd0;
    end else begin
      if (seq_step) begin
        ch_idx <= ch_idx + 2'd1;
      end
      if (seq_advance) begin
        if (pos_last) begin
          pos_idx <= '0;
          if (line_last) begin
            line_idx <= '0;
            pass_idx <= pass_idx + 2'd1;
          end else begin
            line_idx <= line_idx + CW'(1);
          end
        end else begin
          pos_idx <= pos_idx + CW'(1);
        end
      end
    end
  end

  // tile store: one write port, one registered read port
  logic [31:0]   tile_mem [DEPTH];
  logic [31:0]   rdata;
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   px_out;

  assign mem_re    = (in_accept && opcode == fpeb_pkg::OP_READ && in_inside) || seq_read;
  assign mem_we    = (in_accept && opcode == fpeb_pkg::OP_WRITE && in_inside) || seq_write;
  assign mem_raddr = seq_read ? blur_addr : port_addr;
  assign mem_waddr = seq_write ? blur_addr : port_addr;
  assign mem_wdata = seq_write ? px_out : in_pixel;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tile_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= tile_mem[mem_raddr];
    end
  end

  // shared channel update unit: acc += ((p << 4) - acc) * alpha / 16
  logic [11:0]        acc [4];
  logic [11:0]        acc_sel;
  logic [7:0]         tgt_byte;
  logic signed [12:0] diff;
  logic signed [5:0]  alpha_s;
  logic signed [18:0] prod;
  logic signed [18:0] biased;
  logic signed [18:0] quot;
  logic [18:0]        sum_full;
  logic [11:0]        acc_new;

  assign acc_sel  = acc[ch_idx];
  assign tgt_byte = rdata[{ch_idx, 3'b000} +: 8];
  assign alpha_s  = $signed({1'b0, alpha});
  assign diff     = $signed({1'b0, tgt_byte, 4'b0000}) - $signed({1'b0, acc_sel});
  assign prod     = diff * alpha_s;
  // bias negative products so the shift truncates toward zero
  assign biased   = prod + (prod[18] ? 19'sd15 : 19'sd0);
  assign quot     = biased >>> 4;
  assign sum_full = 19'(quot) + 19'(acc_sel);
  assign acc_new  = sum_full[11:0];

  // accumulators and the pixel being rebuilt
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        acc[k] <= 12'd0;
      end
    end else if (seq_seed) begin
      for (int k = 0; k < 4; k++) begin
        acc[k] <= {rdata[8*k +: 8], 4'b0000};
      end
    end else if (seq_step) begin
      acc[ch_idx] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_step) begin
      px_out[{ch_idx, 3'b000} +: 8] <= acc_new[11:4];
    end
  end

  // result register
  logic [1:0] kind_q;
  logic       from_mem;

  assign s_tready = (state == fpeb_pkg::ST_IDLE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      kind_q   <= fpeb_pkg::OP_WRITE;
      from_mem <= 1'b0;
    end else if (in_accept && opcode != fpeb_pkg::OP_BLUR) begin
      m_tvalid <= 1'b1;
      kind_q   <= opcode;
      from_mem <= (opcode == fpeb_pkg::OP_READ) && in_inside;
    end else if (blur_done) begin
      m_tvalid <= 1'b1;
      kind_q   <= fpeb_pkg::OP_BLUR;
      from_mem <= 1'b0;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tuser = kind_q;
  assign m_tdata = from_mem ? rdata : 32'd0;

  // a blur in progress holds no result
  assert property (@(posedge clk) disable iff (rst)
    (state == fpeb_pkg::ST_RD || state == fpeb_pkg::ST_CALC || state == fpeb_pkg::ST_WR)
      |-> !m_tvalid)
    else $error("result pending during blur sweep");

  // each pixel update starts on the first channel
  assert property (@(posedge clk) disable iff (rst)
    (state == fpeb_pkg::ST_RD) |-> (ch_idx == 2'd0))
    else $error("channel counter out of step at pixel read");

  // a write or read request has its result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser != fpeb_pkg::OP_BLUR) |=> m_tvalid)
    else $error("missing result after single-cycle request");

  // the store is never read and written by the sequencer together
  assert property (@(posedge clk) disable iff (rst)
    !(seq_read && seq_write))
    else $error("store read and write in the same sweep cycle");

endmodule

`default_nettype wire
